FILE: design/wmld_pkg.sv
// Shared types and constants for the windowed mean liftoff detector.
`default_nettype none

package wmld_pkg;

	localparam int NPOS     = 4;
	localparam int PRESS_W  = 20;
	localparam int POS_W    = 12;
	localparam int ACCEL_W  = 16;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_MARGIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_THRESHOLD = 2'd1;

	localparam logic [CFG_W-1:0]          MARGIN_RESET    = 16'd20;
	localparam logic signed [ACCEL_W-1:0] THRESHOLD_RESET = 16'sd1024;

	typedef struct packed {
		logic [PRESS_W-1:0]        pressure_sample;
		logic [POS_W-1:0]          position_0;
		logic [POS_W-1:0]          position_1;
		logic [POS_W-1:0]          position_2;
		logic [POS_W-1:0]          position_3;
		logic signed [ACCEL_W-1:0] vertical_accel;
	} sample_t;

	typedef struct packed {
		logic [PRESS_W-1:0] mean_pressure;
		logic [POS_W-1:0]   mean_position_0;
		logic [POS_W-1:0]   mean_position_1;
		logic [POS_W-1:0]   mean_position_2;
		logic [POS_W-1:0]   mean_position_3;
		logic               liftoff_flag;
		logic               liftoff_event;
	} result_t;

	// One slot of the sliding window: a pressure sample and a position frame.
	typedef struct packed {
		logic [PRESS_W-1:0]         pressure;
		logic [NPOS-1:0][POS_W-1:0] position;
	} window_entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIVIDE
	} wmld_state_t;

endpackage

`default_nettype wire

FILE: design/wmld_window_mem.sv
// Window store: one synchronous memory holding the last pressure and position samples.
`default_nettype none

module wmld_window_mem
	import wmld_pkg::*;
#(
	parameter int DEPTH = 10,
	parameter int AW    = 4
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire window_entry_t wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output window_entry_t      rd_data
);

	window_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: design/wmld_divider.sv
// Restoring serial divider that produces one quotient bit per cycle.
`default_nettype none

module wmld_divider #(
	parameter int DW = 24,
	parameter int VW = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output logic               busy,
	output logic [DW-1:0]      quotient
);

	localparam int CNTW = $clog2(DW + 1);

	logic [CNTW-1:0] cnt_q;
	logic [VW-1:0]   rem_q;
	logic [VW-1:0]   div_q;
	logic [DW-1:0]   quo_q;
	logic [VW:0]     trial;
	logic            fits;

	// Bring down the next dividend bit and try to take the divisor off.
	assign trial    = {rem_q, quo_q[DW-1]};
	assign fits     = trial >= {1'b0, div_q};
	assign busy     = cnt_q != '0;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNTW'(DW);
		end else if (busy) begin
			cnt_q <= cnt_q - CNTW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy) begin
			rem_q <= fits ? VW'(trial - {1'b0, div_q}) : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

endmodule

`default_nettype wire

FILE: design/windowed_mean_liftoff_detect.sv
// Top level of the windowed mean liftoff detector: control, running sums and liftoff test.
// A request is accepted in idle, the window slot is read on that edge and updated in the
// next, then five serial dividers run side by side on PW = 20 + clog2(WINDOW)-bit sums;
// the means are loaded once the pressure divider, the last to finish, is done and the result
// register has room. A new request is taken only after that load, when the block is idle again.
// Reset is asynchronous and active low; it clears control state, sums, counts and the liftoff
// latch, and needs no clearing pass over the window memory.
`default_nettype none

module windowed_mean_liftoff_detect
	import wmld_pkg::*;
#(
	parameter int WINDOW = 10
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 sample_valid,
	output logic                      sample_ready,
	input  wire sample_t              sample,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output result_t                   result,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	// The sums must hold WINDOW full-scale samples without wrapping.
	localparam int PSUM_W = PRESS_W + $clog2(WINDOW);
	localparam int QSUM_W = POS_W + $clog2(WINDOW);
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	// Configuration registers. The port never stalls.
	logic [CFG_W-1:0]          margin_q;
	logic signed [ACCEL_W-1:0] threshold_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q    <= MARGIN_RESET;
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PRESSURE_MARGIN: margin_q    <= cfg_data;
				CFG_ACCEL_THRESHOLD: threshold_q <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	// Control state machine. A request is taken in idle, the memory is read on the same
	// edge, the update and divider start happen in the following cycle, and the block then
	// waits for the dividers and for room in the result register.
	wmld_state_t state_q, state_d;
	logic        accept;
	logic        do_update;
	logic        load;
	logic        div_done;
	logic [NPOS:0] div_busy;
	logic        result_valid_q;
	result_t     result_q;

	assign accept = sample_valid && sample_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (div_done && (!result_valid_q || result_ready)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		sample_ready = 1'b0;
		do_update    = 1'b0;
		load         = 1'b0;
		case (state_q)
			ST_IDLE:   sample_ready = 1'b1;
			ST_UPDATE: do_update    = 1'b1;
			ST_DIVIDE: load         = div_done && (!result_valid_q || result_ready);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// The accepted frame is held for the update cycle.
	sample_t sample_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
		end
	end

	// Window memory. Slots are filled in order from zero, so until the window is full the
	// slot being replaced has never been written and stands for zero. The fill count
	// therefore replaces any per-entry valid bits.
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	logic              full;
	window_entry_t     old_entry;
	window_entry_t     new_entry;

	assign full    = count_q == CNT_W'(WINDOW);
	assign count_d = full ? count_q : count_q + CNT_W'(1);

	assign new_entry.pressure    = sample_s1.pressure_sample;
	assign new_entry.position[0] = sample_s1.position_0;
	assign new_entry.position[1] = sample_s1.position_1;
	assign new_entry.position[2] = sample_s1.position_2;
	assign new_entry.position[3] = sample_s1.position_3;

	wmld_window_mem #(
		.DEPTH (WINDOW),
		.AW    (SLOT_W)
	) u_window (
		.clk     (clk),
		.wr_en   (do_update),
		.wr_addr (slot_q),
		.wr_data (new_entry),
		.rd_en   (accept),
		.rd_addr (slot_q),
		.rd_data (old_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			count_q <= '0;
		end else if (do_update) begin
			slot_q  <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
			count_q <= count_d;
		end
	end

	// Running sums: take off the sample leaving the window and add the new one.
	logic [PSUM_W-1:0] psum_q, psum_d;
	logic [QSUM_W-1:0] qsum_q [NPOS];
	logic [QSUM_W-1:0] qsum_d [NPOS];
	logic [PRESS_W-1:0] p_leaving;

	assign p_leaving = full ? old_entry.pressure : '0;
	assign psum_d    = psum_q - PSUM_W'(p_leaving) + PSUM_W'(new_entry.pressure);

	always_comb begin
		for (int i = 0; i < NPOS; i++) begin
			qsum_d[i] = qsum_q[i] - QSUM_W'(full ? old_entry.position[i] : '0)
				+ QSUM_W'(new_entry.position[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psum_q <= '0;
			for (int i = 0; i < NPOS; i++) begin
				qsum_q[i] <= '0;
			end
		end else if (do_update) begin
			psum_q <= psum_d;
			for (int i = 0; i < NPOS; i++) begin
				qsum_q[i] <= qsum_d[i];
			end
		end
	end

	// Five dividers start together on the new sums, with the count after this sample as the
	// divisor, so it is never zero. The pressure lane has the widest dividend and finishes last.
	logic [PSUM_W-1:0] pquot;
	logic [QSUM_W-1:0] qquot [NPOS];

	wmld_divider #(
		.DW (PSUM_W),
		.VW (CNT_W)
	) u_div_pressure (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (do_update),
		.dividend (psum_d),
		.divisor  (count_d),
		.busy     (div_busy[NPOS]),
		.quotient (pquot)
	);

	for (genvar g = 0; g < NPOS; g++) begin : g_pos_div
		wmld_divider #(
			.DW (QSUM_W),
			.VW (CNT_W)
		) u_div_position (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (do_update),
			.dividend (qsum_d[g]),
			.divisor  (count_d),
			.busy     (div_busy[g]),
			.quotient (qquot[g])
		);
	end

	assign div_done = div_busy == '0;

	// Liftoff test. The first frame captures the reference before the test, so it is
	// compared against its own pressure. The test p - margin < ref is done as
	// p < ref + margin in one bit more than the pressure, which can never wrap.
	logic [PRESS_W-1:0] ref_q;
	logic [PRESS_W-1:0] ref_now;
	logic               ref_taken_q;
	logic               latched_q;
	logic               event_q;
	logic               press_low;
	logic               accel_high;
	logic               fire;

	assign ref_now    = ref_taken_q ? ref_q : new_entry.pressure;
	assign press_low  = {1'b0, new_entry.pressure}
		< ({1'b0, ref_now} + (PRESS_W + 1)'(margin_q));
	assign accel_high = sample_s1.vertical_accel > threshold_q;
	assign fire       = !latched_q && press_low && accel_high;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q       <= '0;
			ref_taken_q <= 1'b0;
			latched_q   <= 1'b0;
			event_q     <= 1'b0;
		end else if (do_update) begin
			if (!ref_taken_q) begin
				ref_q       <= new_entry.pressure;
				ref_taken_q <= 1'b1;
			end
			if (fire) begin
				latched_q <= 1'b1;
			end
			event_q <= fire;
		end
	end

	// Result register: it takes the finished means while the next request may already be
	// waiting at the input, and holds them until the consumer takes them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q.mean_pressure   <= pquot[PRESS_W-1:0];
			result_q.mean_position_0 <= qquot[0][POS_W-1:0];
			result_q.mean_position_1 <= qquot[1][POS_W-1:0];
			result_q.mean_position_2 <= qquot[2][POS_W-1:0];
			result_q.mean_position_3 <= qquot[3][POS_W-1:0];
			result_q.liftoff_flag    <= latched_q;
			result_q.liftoff_event   <= event_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// A result waiting to be taken is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!result_valid_q || result_ready))
		else $error("result register loaded while still occupied");

	// The fill count and the write slot stay within the window.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= CNT_W'(WINDOW)) && (slot_q <= SLOT_W'(WINDOW - 1)))
		else $error("window count or slot out of range");

	// Until the window is full, the write slot follows the count of samples.
	a_warmup_slot: assert property (@(posedge clk) disable iff (!arst_n)
		!full |-> (CNT_W'(slot_q) == count_q))
		else $error("write slot out of step with fill count during warm-up");

	// All dividers are running in the cycle after they are started.
	a_div_started: assert property (@(posedge clk) disable iff (!arst_n)
		do_update |=> (div_busy == '1))
		else $error("divider failed to start");

endmodule

`default_nettype wire

FILE: dv/tb_windowed_mean_liftoff_detect.sv
// Self-checking testbench for the windowed mean liftoff detector: directed frames, then random phases.
`timescale 1ns / 100ps

module tb_windowed_mean_liftoff_detect;
	import wmld_pkg::*;

	// The block is built with its default window. The testbench keeps its own window of the
	// same depth and predicts every result from the frames it has seen accepted.
	localparam int WIN          = 10;
	localparam int PHASE_ITEMS  = 445;
	localparam int DRAIN_CYCLES = 40;
	localparam int REPORT_LIMIT = 10;

	// Register indexes that the block has no register behind; writes to them are dropped.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	localparam logic [PRESS_W-1:0]        PRESS_MAX = '1;
	localparam logic [POS_W-1:0]          POS_MAX   = '1;
	localparam logic signed [ACCEL_W-1:0] ACCEL_MIN = 16'sh8000;
	localparam logic signed [ACCEL_W-1:0] ACCEL_MAX = 16'sh7FFF;

	logic                 clk;
	logic                 arst_n;
	logic                 sample_valid;
	logic                 sample_ready;
	sample_t              sample;
	logic                 result_valid;
	logic                 result_ready;
	result_t              result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	windowed_mean_liftoff_detect #(
		.WINDOW(WIN)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample      (sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Shadow copy of the block's configuration and state.
	logic [CFG_W-1:0]          shadow_margin;
	logic signed [ACCEL_W-1:0] shadow_threshold;
	logic [PRESS_W-1:0]        win_pressure [WIN];
	logic [POS_W-1:0]          win_position [WIN][NPOS];
	logic [31:0]               sum_pressure;
	logic [31:0]               sum_position [NPOS];
	int                        slot_next;
	int                        frames_held;
	logic [PRESS_W-1:0]        ref_pressure;
	bit                        ref_captured;
	bit                        lifted;

	// Means and liftoff flags still owed by the block, oldest first.
	result_t awaited_results [$];
	int      fault_count;

	// Per-side counters of requests still to go without idle cycles.
	int send_calm;
	int recv_calm;

	typedef struct {
		sample_t frame;
		bit      typed;
		result_t want;
	} plan_row_t;

	plan_row_t plan [$];

	// Applies one frame to the shadow state and returns the result the block must give for it.
	function automatic result_t predict_frame_result(input sample_t f);
		result_t          r;
		logic [POS_W-1:0] pos [NPOS];
		longint           lowered;
		pos[0] = f.position_0;
		pos[1] = f.position_1;
		pos[2] = f.position_2;
		pos[3] = f.position_3;
		sum_pressure = sum_pressure - win_pressure[slot_next] + f.pressure_sample;
		win_pressure[slot_next] = f.pressure_sample;
		for (int i = 0; i < NPOS; i++) begin
			sum_position[i] = sum_position[i] - win_position[slot_next][i] + pos[i];
			win_position[slot_next][i] = pos[i];
		end
		slot_next = (slot_next + 1 == WIN) ? 0 : slot_next + 1;
		if (frames_held < WIN)
			frames_held++;
		// The divisor counts the frame just added, so it is never zero.
		r.mean_pressure   = PRESS_W'(sum_pressure / unsigned'(frames_held));
		r.mean_position_0 = POS_W'(sum_position[0] / unsigned'(frames_held));
		r.mean_position_1 = POS_W'(sum_position[1] / unsigned'(frames_held));
		r.mean_position_2 = POS_W'(sum_position[2] / unsigned'(frames_held));
		r.mean_position_3 = POS_W'(sum_position[3] / unsigned'(frames_held));
		r.liftoff_event   = 1'b0;
		// The reference is taken before the test, so the first frame is judged against itself.
		if (!ref_captured) begin
			ref_captured = 1'b1;
			ref_pressure = f.pressure_sample;
		end
		// The pressure less the margin may go negative; the comparison must not wrap.
		if (!lifted) begin
			lowered = longint'(f.pressure_sample) - longint'(shadow_margin);
			if (lowered < longint'(ref_pressure) && $signed(f.vertical_accel) > shadow_threshold) begin
				lifted          = 1'b1;
				r.liftoff_event = 1'b1;
			end
		end
		r.liftoff_flag = lifted;
		return r;
	endfunction

	// Draws the idle cycles ahead of the next request, with an occasional run of back-to-back requests.
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 31) == 0)
			calm = $urandom_range(20, 60);
		return $urandom_range(0, 3);
	endfunction

	// A field value that lands on all zeros or all ones now and then, and is uniform otherwise.
	function automatic logic [31:0] biased_bits(input int width);
		logic [31:0] ones;
		ones = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
		case ($urandom_range(0, 7))
			0: begin
				return 32'd0;
			end
			1: begin
				return ones;
			end
			default: begin
				return $urandom & ones;
			end
		endcase
	endfunction

	function automatic sample_t mk_frame(input logic [PRESS_W-1:0] p, input logic [POS_W-1:0] q0,
			input logic [POS_W-1:0] q1, input logic [POS_W-1:0] q2, input logic [POS_W-1:0] q3,
			input logic signed [ACCEL_W-1:0] acc);
		sample_t f;
		f.pressure_sample = p;
		f.position_0      = q0;
		f.position_1      = q1;
		f.position_2      = q2;
		f.position_3      = q3;
		f.vertical_accel  = acc;
		return f;
	endfunction

	function automatic result_t mk_means(input logic [PRESS_W-1:0] p, input logic [POS_W-1:0] q0,
			input logic [POS_W-1:0] q1, input logic [POS_W-1:0] q2, input logic [POS_W-1:0] q3,
			input logic flag, input logic ev);
		result_t r;
		r.mean_pressure   = p;
		r.mean_position_0 = q0;
		r.mean_position_1 = q1;
		r.mean_position_2 = q2;
		r.mean_position_3 = q3;
		r.liftoff_flag    = flag;
		r.liftoff_event   = ev;
		return r;
	endfunction

	function automatic void add_row(input sample_t f, input bit typed, input result_t want);
		plan_row_t row;
		row.frame = f;
		row.typed = typed;
		row.want  = want;
		plan.push_back(row);
	endfunction

	function automatic sample_t random_frame();
		return mk_frame(PRESS_W'(biased_bits(PRESS_W)), POS_W'(biased_bits(POS_W)),
			POS_W'(biased_bits(POS_W)), POS_W'(biased_bits(POS_W)), POS_W'(biased_bits(POS_W)),
			ACCEL_W'(biased_bits(ACCEL_W)));
	endfunction

	// A random frame pulled towards the liftoff boundary, so that both conditions are tried
	// just either side of their limits before the latch closes.
	function automatic sample_t liftoff_probe_frame();
		sample_t f;
		int      p_try;
		int      a_try;
		f = random_frame();
		if ($urandom_range(0, 7) == 0) begin
			p_try = int'(shadow_margin) + int'($urandom_range(0, 4)) - 2;
			if (p_try < 0)
				p_try = 0;
			f.pressure_sample = PRESS_W'(p_try);
		end
		if ($urandom_range(0, 1) == 0) begin
			a_try = int'(shadow_threshold) + int'($urandom_range(0, 4)) - 2;
			if (a_try < -32768)
				a_try = -32768;
			if (a_try > 32767)
				a_try = 32767;
			f.vertical_accel = ACCEL_W'(a_try);
		end
		return f;
	endfunction

	task automatic note_fault(input string msg);
		fault_count++;
		if (fault_count <= REPORT_LIMIT)
			$display("%s", msg);
	endtask

	// Offers one frame request and, once it is taken, records what the block owes for it.
	// Valid is left high afterwards so that a back-to-back request needs no second assignment.
	task automatic send_frame(input sample_t f, input bit typed, input result_t want);
		int      gap;
		result_t predicted;
		gap = draw_gap(send_calm);
		if (gap != 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample       <= f;
		sample_valid <= 1'b1;
		do @(posedge clk); while (!(sample_valid && sample_ready));
		predicted = predict_frame_result(f);
		awaited_results.push_back(typed ? want : predicted);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		if (idx == CFG_PRESSURE_MARGIN)
			shadow_margin = value;
		else if (idx == CFG_ACCEL_THRESHOLD)
			shadow_threshold = value;
	endtask

	task automatic wait_for_results();
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	// One phase: let the block drain, set both registers, then send a run of random frames.
	task automatic run_phase(input logic [CFG_W-1:0] margin, input logic [CFG_W-1:0] threshold,
			input bit probe);
		sample_valid <= 1'b0;
		wait_for_results();
		write_reg(CFG_PRESSURE_MARGIN, margin);
		write_reg(CFG_ACCEL_THRESHOLD, threshold);
		cfg_valid <= 1'b0;
		repeat (PHASE_ITEMS)
			send_frame(probe ? liftoff_probe_frame() : random_frame(), 1'b0, '0);
	endtask

	// Result side: takes result requests with random stalls and checks each one against the
	// oldest outstanding prediction.
	initial begin : result_sink
		int      gap;
		result_t got;
		result_t want;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = draw_gap(recv_calm);
			if (gap != 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!(result_valid && result_ready));
			got = result;
			if (awaited_results.size() == 0) begin
				note_fault($sformatf("unexpected result %h with nothing outstanding", got));
			end else begin
				want = awaited_results.pop_front();
				if (got.mean_pressure !== want.mean_pressure
						|| got.mean_position_0 !== want.mean_position_0
						|| got.mean_position_1 !== want.mean_position_1
						|| got.mean_position_2 !== want.mean_position_2
						|| got.mean_position_3 !== want.mean_position_3
						|| got.liftoff_flag !== want.liftoff_flag
						|| got.liftoff_event !== want.liftoff_event)
					note_fault($sformatf(
						"mismatch: expected p=%h pos=%h %h %h %h flag=%b event=%b, got p=%h pos=%h %h %h %h flag=%b event=%b",
						want.mean_pressure, want.mean_position_0, want.mean_position_1,
						want.mean_position_2, want.mean_position_3, want.liftoff_flag,
						want.liftoff_event, got.mean_pressure, got.mean_position_0,
						got.mean_position_1, got.mean_position_2, got.mean_position_3,
						got.liftoff_flag, got.liftoff_event));
			end
		end
	end

	initial begin : stimulus
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample       = '0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_PRESSURE_MARGIN;
		cfg_data     = '0;
		fault_count  = 0;
		send_calm    = 0;
		recv_calm    = 0;

		// The shadow state starts where reset leaves the block.
		shadow_margin    = MARGIN_RESET;
		shadow_threshold = THRESHOLD_RESET;
		sum_pressure     = '0;
		slot_next        = 0;
		frames_held      = 0;
		ref_pressure     = '0;
		ref_captured     = 1'b0;
		lifted           = 1'b0;
		for (int i = 0; i < WIN; i++) begin
			win_pressure[i] = '0;
			for (int j = 0; j < NPOS; j++)
				win_position[i][j] = '0;
		end
		for (int j = 0; j < NPOS; j++)
			sum_position[j] = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Writes to the unused indexes must leave both registers at their reset values; the
		// boundary frames below would latch liftoff if the threshold had been disturbed.
		write_reg(CFG_SPARE_2, 16'h0000);
		write_reg(CFG_SPARE_3, 16'hFFFF);
		cfg_valid <= 1'b0;

		// Directed frames at the reset settings. The first frame sets the reference to zero, so
		// from then on the pressure condition holds only for pressures below the margin.
		// First frame: the pressure test holds against itself, the acceleration sits exactly on
		// the threshold, so nothing latches.
		add_row(mk_frame('0, '0, '0, '0, '0, THRESHOLD_RESET), 1'b1,
			mk_means('0, '0, '0, '0, '0, 1'b0, 1'b0));
		// Warm-up over two frames: the sum is halved.
		add_row(mk_frame(PRESS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, ACCEL_MAX), 1'b1,
			mk_means(20'h7FFFF, 12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF, 1'b0, 1'b0));
		// Just under the margin, acceleration on the threshold.
		add_row(mk_frame(20'd19, '0, '0, '0, '0, THRESHOLD_RESET), 1'b0, '0);
		// Exactly on the margin, acceleration one step above.
		add_row(mk_frame(20'd20, POS_MAX, POS_MAX, POS_MAX, POS_MAX, 16'sd1025), 1'b0, '0);
		add_row(mk_frame('0, 12'h123, 12'h456, 12'h789, 12'hABC, ACCEL_MIN), 1'b0, '0);
		// Eleven full-scale frames: the window fills with them and then wraps.
		for (int k = 0; k < 11; k++)
			add_row(mk_frame(PRESS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, ACCEL_MAX), k >= 9,
				mk_means(PRESS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, 1'b0, 1'b0));
		add_row(mk_frame('0, '0, '0, '0, '0, 16'sd0), 1'b0, '0);
		add_row(mk_frame(20'hAAAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 16'sh5555), 1'b0, '0);
		add_row(mk_frame(20'h55555, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 16'shAAAA), 1'b0, '0);
		add_row(mk_frame(20'hAAAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 16'shAAAA), 1'b0, '0);
		add_row(mk_frame('0, POS_MAX, '0, POS_MAX, '0, THRESHOLD_RESET), 1'b0, '0);
		foreach (plan[i])
			send_frame(plan[i].frame, plan[i].typed, plan[i].want);

		// No margin: the pressure can never fall below the zero reference.
		run_phase(16'd0, ACCEL_MIN, 1'b0);
		// Largest margin with the highest threshold: no acceleration can pass.
		run_phase(16'hFFFF, ACCEL_MAX, 1'b0);
		// Random settings with frames aimed at the boundary; liftoff latches somewhere in here.
		run_phase(CFG_W'($urandom_range(3, 65535)), CFG_W'($urandom_range(0, 65533) + 32768),
			1'b1);
		// After the latch: the flag must hold and no further event may appear.
		run_phase(CFG_W'($urandom), CFG_W'($urandom), 1'b0);

		sample_valid <= 1'b0;
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog well beyond the slowest correct run.
	initial begin : watchdog
		#4000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: filelist.f
design/wmld_pkg.sv
design/wmld_window_mem.sv
design/wmld_divider.sv
design/windowed_mean_liftoff_detect.sv
dv/tb_windowed_mean_liftoff_detect.sv
